// ===== src/rqm_pkg.sv =====
`default_nettype none
package rqm_pkg;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] amount;
  } rqm_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] usable_remaining;
    logic [63:0] credit_remaining;
    logic [63:0] credit_used;
    logic [63:0] system_used;
  } rqm_out_t;

  // register indexes
  localparam logic [2:0] REG_DISK_LIMIT     = 3'd0;
  localparam logic [2:0] REG_NETWORK_LIMIT  = 3'd1;
  localparam logic [2:0] REG_COMPUTE_LIMIT  = 3'd2;
  localparam logic [2:0] REG_DISK_PRICE     = 3'd3;
  localparam logic [2:0] REG_NETWORK_PRICE  = 3'd4;
  localparam logic [2:0] REG_COMPUTE_PRICE  = 3'd5;
  localparam logic [2:0] REG_SESSION_ACTIVE = 3'd6;
  localparam logic [2:0] REG_SESSION_BUDGET = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_LIMIT    = 2'd1;
  localparam logic [1:0] ST_CREDIT   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [1:0] MODE_COMPUTE = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  localparam logic [63:0] ALL_ONES = {64{1'b1}};

  // controller to datapath
  typedef struct packed {
    logic load;      // latch item, check limit
    logic mul_start; // clear multiplier
    logic mul_step;  // one multiplier bit
    logic commit;    // decide status, update state
    logic div_start; // clear divider
    logic div_step;  // one divider bit
    logic finish;    // build result
  } rqm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_mul;
    logic need_div;
  } rqm_sts_t;

endpackage
`default_nettype wire

// ===== src/rqm_datapath.sv =====
`default_nettype none
module rqm_datapath
  import rqm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [63:0] cfg_val,
  input  wire rqm_in_t     in_item,
  input  wire rqm_cmd_t    cmd,
  output rqm_sts_t         sts,
  output rqm_out_t         result
);

  logic [63:0] limit_r [3];
  logic [63:0] price_r [3];
  logic        active_r;
  logic [63:0] budget_r;
  logic [63:0] left_r [3];
  logic [63:0] sys_r [3];
  logic [63:0] credit_r;

  logic [1:0]  mode_r;
  logic [63:0] amt_r;
  logic        over_r;
  logic [1:0]  status_r;
  logic [63:0] price_sel_r;

  // shift-add multiplier, 128-bit product
  logic [127:0] prod_r;
  logic [127:0] mcand_r;
  logic [63:0]  mplier_r;
  // restoring divider
  logic [63:0]  quot_r;
  logic [64:0]  rem_r;
  logic [63:0]  dvd_r;

  logic [1:0] m;
  logic       over_nxt;
  logic [64:0] rem_sh;
  logic [63:0] left_sel;
  logic        price_nz;
  logic        charge_ok;

  assign m        = in_item.mode;
  assign left_sel = (mode_r == MODE_NONE) ? 64'd0 : left_r[mode_r];
  assign price_nz = (mode_r != MODE_NONE) && (price_r[mode_r] != 64'd0);

  // session charge that fits the credit
  assign charge_ok = (mode_r != MODE_NONE) && !over_r && active_r &&
                     (prod_r[127:64] == 64'd0) && (prod_r[63:0] <= credit_r);

  always_comb begin
    if (m == MODE_NONE)         over_nxt = 1'b1;
    else if (m == MODE_COMPUTE) over_nxt = in_item.amount > left_r[m];
    else                        over_nxt = in_item.amount >= left_r[m];
  end

  assign sts.need_mul = !over_r && active_r;
  assign sts.need_div = active_r && price_nz;
  assign rem_sh       = {rem_r[63:0], dvd_r[63]};

  // configuration and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        limit_r[i] <= ALL_ONES;
        price_r[i] <= 64'd0;
        left_r[i]  <= ALL_ONES;
        sys_r[i]   <= 64'd0;
      end
      active_r <= 1'b0;
      budget_r <= 64'd0;
      credit_r <= 64'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DISK_LIMIT, REG_NETWORK_LIMIT, REG_COMPUTE_LIMIT: begin
          for (int i = 0; i < 3; i++) begin
            left_r[i] <= (cfg_idx[1:0] == 2'(i)) ? cfg_val : limit_r[i];
            sys_r[i]  <= 64'd0;
          end
          limit_r[cfg_idx[1:0]] <= cfg_val;
        end
        REG_DISK_PRICE:     price_r[0] <= cfg_val;
        REG_NETWORK_PRICE:  price_r[1] <= cfg_val;
        REG_COMPUTE_PRICE:  price_r[2] <= cfg_val;
        REG_SESSION_ACTIVE: begin
          active_r <= cfg_val[0];
          credit_r <= budget_r;
        end
        REG_SESSION_BUDGET: begin
          budget_r <= cfg_val;
          credit_r <= cfg_val;
        end
        default: ;
      endcase
    end else if (cmd.commit && mode_r != MODE_NONE && !over_r) begin
      if (!active_r) begin
        sys_r[mode_r]  <= sys_r[mode_r] + amt_r;
        left_r[mode_r] <= left_r[mode_r] - amt_r;
      end else if (prod_r[127:64] == 64'd0 && prod_r[63:0] <= credit_r) begin
        credit_r       <= credit_r - prod_r[63:0];
        left_r[mode_r] <= left_r[mode_r] - amt_r;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= m;
      amt_r  <= in_item.amount;
      over_r <= over_nxt;
      price_sel_r <= (m == MODE_NONE) ? 64'd0 : price_r[m];
    end
    if (cmd.mul_start) begin
      prod_r   <= 128'd0;
      mcand_r  <= {64'd0, amt_r};
      mplier_r <= price_sel_r;
    end else if (cmd.mul_step) begin
      if (mplier_r[0]) prod_r <= prod_r + mcand_r;
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
    if (cmd.commit) begin
      if (over_r)                        status_r <= ST_LIMIT;
      else if (!active_r)                status_r <= ST_OK;
      else if (prod_r[127:64] != 64'd0)  status_r <= ST_OVERFLOW;
      else if (prod_r[63:0] > credit_r)  status_r <= ST_CREDIT;
      else                               status_r <= ST_OK;
    end
    // divide the credit left after this item's charge
    if (cmd.div_start) begin
      quot_r <= 64'd0;
      rem_r  <= 65'd0;
      dvd_r  <= charge_ok ? credit_r - prod_r[63:0] : credit_r;
    end else if (cmd.div_step) begin
      dvd_r <= dvd_r << 1;
      if (rem_sh >= {1'b0, price_r[mode_r]}) begin
        rem_r  <= rem_sh - {1'b0, price_r[mode_r]};
        quot_r <= {quot_r[62:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        quot_r <= {quot_r[62:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      result.status <= status_r;
      result.usable_remaining <= (sts.need_div && quot_r < left_sel) ? quot_r : left_sel;
      result.credit_remaining <= credit_r;
      result.credit_used      <= budget_r - credit_r;
      result.system_used      <= (mode_r == MODE_NONE) ? 64'd0 : sys_r[mode_r];
    end
  end

endmodule
`default_nettype wire

// ===== src/rqm_ctrl.sv =====
`default_nettype none
module rqm_ctrl
  import rqm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic      cfg_ready,
  input  wire rqm_sts_t sts,
  output rqm_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MSET = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_COMM = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       ov_r, ov_nxt;

  // take an item only when the output slot is free or draining
  assign in_ready  = (state_r == S_IDLE) && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign cfg_ready = (state_r == S_IDLE) && !ov_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.load  = 1'b1;
        state_nxt = S_MSET;
      end
      S_MSET: begin
        cmd.mul_start = 1'b1;
        cnt_nxt   = 6'd0;
        state_nxt = sts.need_mul ? S_MUL : S_COMM;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) state_nxt = S_COMM;
      end
      S_COMM: begin
        cmd.commit    = 1'b1;
        cmd.div_start = 1'b1;
        cnt_nxt   = 6'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.need_div) begin
          cmd.div_step = 1'b1;
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r == 6'd63) state_nxt = S_FIN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        ov_nxt     = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 6'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/resource_quota_meter_top.sv =====
// Channel | Handshake           | Payload
// in      | in_valid/in_ready   | in_data  (rqm_in_t: mode, amount)
// out     | out_valid/out_ready | out_data (rqm_out_t: status, usable, credit..)
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
// A result is valid once its item has passed MSET, COMM, DIV and FIN, plus the
// bit-serial multiply (session active, item within limit) and the bit-serial
// divide (session active, price nonzero).
// The result sits in an output register; the next item is taken as it drains.
// Reset is synchronous and active low; no clearing pass.
// Configuration is taken only when no item is in flight or waiting.
`default_nettype none
module resource_quota_meter_top
  import rqm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire rqm_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output rqm_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  rqm_cmd_t cmd;
  rqm_sts_t sts;
  logic     cfg_we;

  // indexes beyond the list are dropped
  assign cfg_we = cfg_valid && cfg_ready && !cfg_index[3];

  rqm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .cfg_ready, .sts, .cmd
  );

  rqm_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_idx(cfg_index[2:0]), .cfg_val(cfg_data),
    .in_item(in_data), .cmd, .sts, .result(out_data)
  );

endmodule
`default_nettype wire

// ===== src/rqm_checker.sv =====
`default_nettype none
module rqm_checker
  import rqm_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire rqm_out_t out_data,
  input wire logic     cfg_ready
);

  // a result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // no result shortly after an accepted item
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !out_valid || $past(out_valid, 1))
    else $error("result too early");

  // configuration never accepted with a result waiting
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !cfg_ready)
    else $error("config taken while busy");

endmodule

bind resource_quota_meter_top rqm_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data, .cfg_ready
);
`default_nettype wire
